@@ src/torus_point_zbuffer_plotter_core_defines.svh @@
// assertion macros for the torus point plotter
// used by the top level; expects clk and rst in scope
`ifndef TORUS_POINT_ZBUFFER_PLOTTER_CORE_DEFINES_SVH
`define TORUS_POINT_ZBUFFER_PLOTTER_CORE_DEFINES_SVH
`ifndef SYNTH
`define TPZ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define TPZ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next cycle check failed");
`else
`define TPZ_ASSERT_IMP(lbl, ante, cons)
`define TPZ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ src/tpz_pkg.sv @@
// shared constants, types and helpers for the torus point plotter
// no dependencies
package tpz_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int STORE_SIZE    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W        = $clog2(STORE_SIZE);
  localparam int X_W           = 9;
  localparam int Y_W           = 8;

  localparam int FRAC          = 13;
  localparam int PI_Q          = 25736;
  localparam int HPI_Q         = 12868;
  localparam int TAU_Q         = 51472;
  localparam int THREE_HPI_Q   = 38604;
  localparam int RING_Q        = 16384;
  localparam int LIFT_Q        = 16384;
  localparam int CAM_DIST_Q    = 65536;
  localparam int PROJ_Q        = 200 * 8192;
  localparam int CENTRE_X      = 160;
  localparam int CENTRE_Y      = 120;
  localparam int DEPTH_MAX     = 65535;

  localparam int DW            = 20;
  localparam int ANG_W         = 18;
  localparam int NUM_W         = 40;
  localparam int DEN_W         = 21;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PLOT  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_ROT_A = 2'd0,
    REG_ROT_B = 2'd1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TRIG,
    ST_ROT,
    ST_NUMX,
    ST_DIVX,
    ST_NUMY,
    ST_DIVY,
    ST_PLACE,
    ST_DIVZ,
    ST_MREAD,
    ST_MWAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                    vld;
    logic [2:0]              tag;
    logic signed [ANG_W-1:0] ang;
  } sin_req_t;

  typedef struct packed {
    logic               vld;
    logic [2:0]         tag;
    logic signed [15:0] val;
  } sin_rsp_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [DW-1:0] qmul(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    logic signed [2*DW-1:0] p;
    logic signed [2*DW-1:0] adj;
    p   = (2*DW)'(a) * (2*DW)'(b);
    adj = p[2*DW-1] ? p + (2*DW)'((1 << FRAC) - 1) : p;
    return DW'(adj >>> FRAC);
  endfunction

endpackage

@@ src/tpz_sin.sv @@
// pipelined fixed point sine: quadrant fold then fifth order polynomial
// depends on tpz_pkg; one angle in per cycle
module tpz_sin (
  input  logic            clk,
  input  logic            rst,
  input  tpz_pkg::sin_req_t req,
  output tpz_pkg::sin_rsp_t rsp
);
  import tpz_pkg::*;

  logic signed [18:0] r;
  logic [13:0] m0;
  logic [5:0]  vld;
  logic [2:0]  tagp [6];
  logic [4:0]  negp;
  logic [13:0] m1, m2s, m3s, m4s;
  logic [14:0] sq2, sq3;
  logic [14:0] cu3;
  logic [16:0] m5;
  logic [12:0] q6;
  logic [10:0] q120;
  logic [13:0] base5;
  logic signed [15:0] res;
  logic [27:0] p2;
  logic [28:0] p3;
  logic [29:0] p5;
  logic [30:0] p6;
  logic [35:0] p120;
  logic [14:0] pv;

  always_comb begin
    r = 19'(req.ang);
    if (r < 0) r = r + 19'(TAU_Q);
    if (r >= 19'(TAU_Q)) r = r - 19'(TAU_Q);
    if (r > 19'(THREE_HPI_Q)) r = r - 19'(TAU_Q);
    else if (r > 19'(HPI_Q)) r = 19'(PI_Q) - r;
    m0 = r[18] ? 14'(-r) : 14'(r);
  end

  assign p2   = 28'(m1) * 28'(m1);
  assign p3   = 29'(sq2) * 29'(m2s);
  assign p5   = 30'(cu3) * 30'(sq3);
  assign p6   = 31'(cu3) * 31'(16'd43691);
  assign p120 = 36'(m5) * 36'(19'd279621);
  assign pv   = 15'(base5) + 15'(q120);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], req.vld};
    end
    tagp[0] <= req.tag;
    for (int i = 1; i < 6; i++) tagp[i] <= tagp[i-1];
    negp <= {negp[3:0], r[18]};
    m1    <= m0;
    sq2   <= p2[27:13];
    m2s   <= m1;
    cu3   <= p3[27:13];
    sq3   <= sq2;
    m3s   <= m2s;
    m5    <= p5[29:13];
    q6    <= p6[30:18];
    m4s   <= m3s;
    q120  <= p120[35:25];
    base5 <= m4s - 14'(q6);
    res   <= negp[4] ? -16'(signed'({1'b0, pv})) : 16'(signed'({1'b0, pv}));
  end

  assign rsp.vld = vld[5];
  assign rsp.tag = tagp[5];
  assign rsp.val = res;

endmodule

@@ src/tpz_div.sv @@
// restoring unsigned divider, one quotient bit per cycle
// depends on tpz_pkg for widths and request types
module tpz_div (
  input  logic              clk,
  input  logic              rst,
  input  tpz_pkg::div_req_t req,
  output tpz_pkg::div_rsp_t rsp
);
  import tpz_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   sh;
  logic             fits;

  assign sh   = {rem, quo[NUM_W-1]};
  assign fits = sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (req.start) begin
      quo <= req.num;
      rem <= '0;
      den <= req.den;
    end else if (busy) begin
      rem <= fits ? DEN_W'(sh - {1'b0, den}) : DEN_W'(sh);
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

@@ src/tpz_store.sv @@
// inverse depth store: single write port, registered read port
// depends on tpz_pkg for size and address width
module tpz_store (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [tpz_pkg::ADDR_W-1:0] wr_addr,
  input  logic [15:0]               wr_data,
  input  logic                      rd_en,
  input  logic [tpz_pkg::ADDR_W-1:0] rd_addr,
  output logic [15:0]               rd_data
);
  import tpz_pkg::*;

  logic [15:0] mem [STORE_SIZE];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

@@ src/torus_point_zbuffer_plotter_core.sv @@
// torus point plotter with inverse depth store, top level
// depends on tpz_pkg, tpz_sin, tpz_div, tpz_store and the defines header
//
// items enter on in_valid/in_stall and one result per item leaves on
// out_valid/out_stall. rotation_a and rotation_b are to be written by the
// user on the cfg port (cfg_ready is always high) while the block is
// idle; the block does not enforce this. one item is worked at a time;
// the next is taken as soon as the result has moved to the output register,
// even if that result is still stalled. plot: eight angles go through the
// six stage sine pipeline, fifteen steps of the shared multiplier make x,
// y and z, then the serial divider projects x and y and forms 1/z, and for
// an on-screen point the store is read and written back if the new inverse
// depth is greater. read: one store entry is read. clear: one store entry
// per cycle, 76800 entries. after reset the same clearing pass runs before
// any item is accepted; cfg writes are taken throughout. when the receiver
// stalls, the result waits in the output register and the block stops at
// its final step once a further result is ready.
`include "torus_point_zbuffer_plotter_core_defines.svh"
module torus_point_zbuffer_plotter_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               opcode,
  input  logic signed [15:0]       theta,
  input  logic signed [15:0]       phi,
  input  logic [tpz_pkg::X_W-1:0]  read_x,
  input  logic [tpz_pkg::Y_W-1:0]  read_y,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     written,
  output logic [tpz_pkg::X_W-1:0]  plot_x,
  output logic [tpz_pkg::Y_W-1:0]  plot_y,
  output logic [15:0]              pixel_color,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [15:0]              cfg_data
);
  import tpz_pkg::*;

  state_t state, state_next;

  logic [15:0] rot_a, rot_b;
  logic [1:0]  op;
  logic signed [15:0] th, ph;
  logic        init;
  logic [ADDR_W-1:0] clr_addr;
  logic [3:0]  cnt, rcnt;
  logic signed [15:0] trig [8];
  logic signed [DW-1:0] ring, tmp, acc, xr, yr, zr;
  logic signed [DW-1:0] opa, opb, prod;
  logic signed [41:0] px, py, qs, nprod, nmag;
  logic        qneg;
  logic [ADDR_W-1:0] idx;
  logic [15:0] oz;
  logic        res_written;
  logic [X_W-1:0] res_x;
  logic [Y_W-1:0] res_y;
  logic [15:0] res_pix;
  logic signed [DEN_W-1:0] dval;
  logic        dpos, zpos, on, rd_in_range, out_free, greater;
  logic signed [ANG_W-1:0] ang_base;
  logic        mem_wr_en, mem_rd_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [15:0] mem_wr_data, mem_rd_data;
  logic [ADDR_W-1:0] rd_idx;

  sin_req_t sin_req;
  sin_rsp_t sin_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  tpz_sin u_sin (.clk(clk), .rst(rst), .req(sin_req), .rsp(sin_rsp));
  tpz_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));
  tpz_store u_store (
    .clk(clk), .wr_en(mem_wr_en), .wr_addr(mem_wr_addr), .wr_data(mem_wr_data),
    .rd_en(mem_rd_en), .rd_addr(idx), .rd_data(mem_rd_data)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = state != ST_IDLE;
  assign out_free  = !out_valid || !out_stall;

  assign dval  = DEN_W'(CAM_DIST_Q) + DEN_W'(zr);
  assign dpos  = !dval[DEN_W-1] && (dval != '0);
  assign zpos  = !zr[DW-1] && (zr != '0);
  assign on    = !px[41] && !py[41] &&
                 (px < 42'(SCREEN_WIDTH * 8192)) && (py < 42'(SCREEN_HEIGHT * 8192));
  assign rd_in_range = ({1'b0, read_x} < (X_W+1)'(SCREEN_WIDTH)) &&
                       ({1'b0, read_y} < (Y_W+1)'(SCREEN_HEIGHT));
  assign rd_idx  = ADDR_W'(ADDR_W'(read_y) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(read_x));
  assign greater = oz > mem_rd_data;
  assign qs      = signed'({2'b00, div_rsp.quo});

  // projection numerator
  always_comb begin
    nprod = 42'(state == ST_NUMY ? yr : xr) * 42'(PROJ_Q);
    nmag  = nprod[41] ? -nprod : nprod;
  end

  // sine request per tag: -cos t, sin t, -cos p, sin p, -cos a, sin a, -cos b, sin b
  always_comb begin
    case (cnt[2:1])
      2'd0:    ang_base = ANG_W'(th);
      2'd1:    ang_base = ANG_W'(ph);
      2'd2:    ang_base = signed'({2'b00, rot_a});
      default: ang_base = signed'({2'b00, rot_b});
    endcase
    sin_req.vld = (state == ST_TRIG) && !cnt[3];
    sin_req.tag = cnt[2:0];
    sin_req.ang = cnt[0] ? ang_base : ang_base - ANG_W'(HPI_Q);
  end

  // rotation step operands
  always_comb begin
    case (cnt)
      4'd0:    begin opa = DW'(trig[5]); opb = DW'(trig[7]); end
      4'd1:    begin opa = tmp;          opb = DW'(trig[3]); end
      4'd2:    begin opa = DW'(trig[6]); opb = DW'(trig[2]); end
      4'd3:    begin opa = ring;         opb = acc;          end
      4'd4:    begin opa = DW'(trig[4]); opb = DW'(trig[7]); end
      4'd5:    begin opa = tmp;          opb = DW'(trig[1]); end
      4'd6:    begin opa = DW'(trig[6]); opb = DW'(trig[5]); end
      4'd7:    begin opa = tmp;          opb = DW'(trig[3]); end
      4'd8:    begin opa = DW'(trig[7]); opb = DW'(trig[2]); end
      4'd9:    begin opa = ring;         opb = acc;          end
      4'd10:   begin opa = DW'(trig[4]); opb = DW'(trig[6]); end
      4'd11:   begin opa = tmp;          opb = DW'(trig[1]); end
      4'd12:   begin opa = DW'(trig[4]); opb = ring;         end
      4'd13:   begin opa = tmp;          opb = DW'(trig[3]); end
      default: begin opa = DW'(trig[5]); opb = DW'(trig[1]); end
    endcase
    prod = qmul(opa, opb);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == ADDR_W'(STORE_SIZE - 1)) state_next = init ? ST_IDLE : ST_DONE;
      ST_IDLE: begin
        if (in_valid) begin
          case (opcode)
            OP_CLEAR: state_next = ST_CLEAR;
            OP_PLOT:  state_next = ST_TRIG;
            OP_READ:  state_next = rd_in_range ? ST_MREAD : ST_DONE;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_TRIG:  if (rcnt == 4'd8) state_next = ST_ROT;
      ST_ROT:   if (cnt == 4'd14) state_next = ST_NUMX;
      ST_NUMX:  state_next = dpos ? ST_DIVX : ST_DONE;
      ST_DIVX:  if (div_rsp.done) state_next = ST_NUMY;
      ST_NUMY:  state_next = ST_DIVY;
      ST_DIVY:  if (div_rsp.done) state_next = ST_PLACE;
      ST_PLACE: state_next = (on && zpos) ? ST_DIVZ : ST_DONE;
      ST_DIVZ:  if (div_rsp.done) state_next = ST_MREAD;
      ST_MREAD: state_next = ST_MWAIT;
      ST_MWAIT: state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    div_req.start = (state == ST_NUMX && dpos) || (state == ST_NUMY) ||
                    (state == ST_PLACE && on && zpos);
    div_req.num   = (state == ST_PLACE) ? NUM_W'(1) << 25 : nmag[NUM_W-1:0];
    div_req.den   = (state == ST_PLACE) ? DEN_W'(zr) : DEN_W'(dval);
    mem_rd_en     = state == ST_MREAD;
    mem_wr_en     = (state == ST_CLEAR) || (state == ST_MWAIT && op == OP_PLOT && greater);
    mem_wr_addr   = (state == ST_CLEAR) ? clr_addr : idx;
    mem_wr_data   = (state == ST_CLEAR) ? 16'd0 : oz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      init      <= 1'b1;
      clr_addr  <= '0;
      rot_a     <= '0;
      rot_b     <= '0;
      cnt       <= '0;
      rcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROT_A: rot_a <= cfg_data;
          REG_ROT_B: rot_b <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_CLEAR) begin
        if (clr_addr == ADDR_W'(STORE_SIZE - 1)) begin
          clr_addr <= '0;
          init     <= 1'b0;
        end else begin
          clr_addr <= clr_addr + 1'b1;
        end
      end
      case (state)
        ST_IDLE: begin
          cnt  <= '0;
          rcnt <= '0;
        end
        ST_TRIG: begin
          if (rcnt == 4'd8) cnt <= '0;
          else if (!cnt[3]) cnt <= cnt + 1'b1;
          if (sin_rsp.vld) rcnt <= rcnt + 1'b1;
        end
        ST_ROT:  cnt <= cnt + 1'b1;
        default: ;
      endcase
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (sin_rsp.vld) trig[sin_rsp.tag] <= sin_rsp.val;
    case (state)
      ST_IDLE: begin
        op          <= opcode;
        th          <= theta;
        ph          <= phi;
        idx         <= rd_idx;
        res_written <= 1'b0;
        res_x       <= '0;
        res_y       <= '0;
        res_pix     <= '0;
      end
      ST_TRIG: ring <= DW'(RING_Q) + DW'(trig[0]);
      ST_ROT: begin
        case (cnt)
          4'd0, 4'd1, 4'd4, 4'd6, 4'd7, 4'd10, 4'd12: tmp <= prod;
          4'd2:    acc <= prod + tmp;
          4'd8:    acc <= prod - tmp;
          4'd3:    xr  <= prod;
          4'd5:    xr  <= xr - prod;
          4'd9:    yr  <= prod;
          4'd11:   yr  <= yr + prod;
          4'd13:   zr  <= prod + DW'(LIFT_Q);
          default: zr  <= zr + prod;
        endcase
      end
      ST_NUMX, ST_NUMY: qneg <= nprod[41];
      ST_DIVX: if (div_rsp.done) px <= (qneg ? -qs : qs) + 42'(CENTRE_X * 8192);
      ST_DIVY: if (div_rsp.done) py <= (qneg ? -qs : qs) + 42'(CENTRE_Y * 8192);
      ST_PLACE: begin
        if (on) begin
          res_x <= px[FRAC +: X_W];
          res_y <= py[FRAC +: Y_W];
          idx   <= ADDR_W'(ADDR_W'(py[FRAC +: Y_W]) * ADDR_W'(SCREEN_WIDTH) +
                           ADDR_W'(px[FRAC +: X_W]));
        end
      end
      ST_DIVZ: begin
        if (div_rsp.done) begin
          oz <= (div_rsp.quo > NUM_W'(DEPTH_MAX)) ? 16'(DEPTH_MAX) : div_rsp.quo[15:0];
        end
      end
      ST_MWAIT: begin
        if (op == OP_PLOT) res_written <= greater;
        else res_pix <= (mem_rd_data != 16'd0) ? 16'hFFFF : 16'd0;
      end
      default: ;
    endcase
    if (state == ST_DONE && out_free) begin
      written     <= res_written;
      plot_x      <= res_x;
      plot_y      <= res_y;
      pixel_color <= res_pix;
    end
  end

  `TPZ_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `TPZ_ASSERT_IMP(a_store_write_states, mem_wr_en, state == ST_CLEAR || state == ST_MWAIT)
  `TPZ_ASSERT_IMP(a_sine_count_bound, state == ST_TRIG, rcnt <= 4'd8)

endmodule
